@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by spq_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property whose consequent is checked in the cycle after the trigger
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;
  localparam int CMD_W        = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value_in;
  } spq_in_t;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] value_out;
    logic                      empty_res;
    logic [COUNT_W-1:0]        count;
  } spq_out_t;

endpackage

@@ hw/rtl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded queue of signed values kept in descending order in one RAM ring.
// ----------------------------------------------------------------------------
//  channel  ports                      handshake
//  input    start, busy, in_data       beat taken when start && !busy
//  result   out_valid, out_data        one-cycle strobe, never stalled
//
// entries sit in a ring between head and tail; remove advances head, insert
// walks back from the tail one entry a cycle, moving each smaller or equal
// entry up by one, until it meets a greater one or passes the head.
// clear, a failed command and an insert into an empty queue finish in idle;
// remove passes through the pop state for the RAM read; insert walks in the
// shift state, plus the place state when the new value lands at the head.
// busy is high while a walk or a read is under way; the result strobes in
// the cycle after the last one. reset empties the queue, no RAM sweep.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  in_data,
  output logic     out_valid,
  output spq_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_POP   = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_PLACE = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [AW-1:0]             head_r, head_nxt;
  logic [AW-1:0]             tail_r, tail_nxt;
  logic [OW-1:0]             occ_r, occ_nxt;
  logic [AW-1:0]             cur_r, cur_nxt;
  logic [AW-1:0]             left_r, left_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic                      out_valid_r, out_valid_nxt;
  spq_out_t                  out_r, out_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(CAPACITY - 1) : p - 1'b1;
  endfunction

  function automatic spq_out_t make_res(input logic ok, input logic [VALUE_W-1:0] v,
                                        input logic [OW-1:0] occ);
    spq_out_t res;
    res.ok        = ok;
    res.value_out = v;
    res.empty_res = (occ == '0);
    res.count     = COUNT_W'(occ);
    return res;
  endfunction

  spq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_r;
    ram_wdata     = val_r;
    ram_raddr     = ptr_dec(tail_r);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          out_nxt       = make_res(1'b0, '0, occ_r);
          case (in_data.cmd)
            CMD_INSERT: begin
              if (occ_r == OW'(CAPACITY)) begin
                out_nxt = make_res(1'b0, '0, occ_r);
              end else if (occ_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = tail_r;
                ram_wdata = in_data.value_in;
                tail_nxt  = ptr_inc(tail_r);
                occ_nxt   = occ_r + 1'b1;
                out_nxt   = make_res(1'b1, '0, occ_r + 1'b1);
              end else begin
                // start the walk at the last stored entry
                out_valid_nxt = 1'b0;
                ram_raddr     = ptr_dec(tail_r);
                cur_nxt       = ptr_dec(tail_r);
                left_nxt      = AW'(occ_r - 1'b1);
                val_nxt       = in_data.value_in;
                state_nxt     = ST_SHIFT;
              end
            end
            CMD_REMOVE: begin
              if (occ_r != '0) begin
                out_valid_nxt = 1'b0;
                ram_raddr     = head_r;
                state_nxt     = ST_POP;
              end
            end
            CMD_CLEAR: begin
              occ_nxt  = '0;
              tail_nxt = head_r;
              out_nxt  = make_res(1'b1, '0, '0);
            end
            default: begin
              out_nxt = make_res(1'b0, '0, occ_r);
            end
          endcase
        end
      end
      ST_POP: begin
        head_nxt      = ptr_inc(head_r);
        occ_nxt       = occ_r - 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = make_res(1'b1, ram_rdata, occ_r - 1'b1);
        state_nxt     = ST_IDLE;
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_inc(cur_r);
        if ($signed(ram_rdata) > val_r) begin
          ram_wdata     = val_r;
          tail_nxt      = ptr_inc(tail_r);
          occ_nxt       = occ_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt       = make_res(1'b1, '0, occ_r + 1'b1);
          state_nxt     = ST_IDLE;
        end else begin
          ram_wdata = ram_rdata;
          if (left_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            ram_raddr = ptr_dec(cur_r);
            cur_nxt   = ptr_dec(cur_r);
            left_nxt  = left_r - 1'b1;
          end
        end
      end
      ST_PLACE: begin
        // new value is the largest: it becomes the head entry
        ram_we        = 1'b1;
        ram_waddr     = cur_r;
        ram_wdata     = val_r;
        tail_nxt      = ptr_inc(tail_r);
        occ_nxt       = occ_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = make_res(1'b1, '0, occ_r + 1'b1);
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    left_r <= left_nxt;
    val_r  <= val_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/spq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/spq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on command and result timing of the priority queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input spq_in_t  in_data,
  input logic     out_valid,
  input spq_out_t out_data
);

  // a result beat closes the command, so the queue is free again
  `SPQ_ASSERT(a_res_not_busy, !out_valid || !busy, "result shown while still busy")

  // a result only follows an accepted beat or a finishing walk or read
  `SPQ_ASSERT(a_res_cause, !out_valid || $past(start && !busy) || $past(busy), "unsolicited result")

  // busy only rises on an accepted command
  `SPQ_ASSERT(a_busy_cause, !$rose(busy) || $past(start), "busy rose without a command")

  // a clear that is taken gives its result in the next cycle
  `SPQ_ASSERT_NEXT(a_quick_res, start && !busy && (in_data.cmd == CMD_CLEAR), out_valid && out_data.ok && (out_data.count == '0), "clear result missing")

  // count stays within capacity where the field can show it
  `SPQ_ASSERT(a_count_range, !out_valid || (CAPACITY >= 32) || (out_data.count <= COUNT_W'(CAPACITY)), "count above capacity")

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

@@ sim/spq_order_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_order_checker
// Watches the command and result channels of the sorted priority queue, keeps
// its own descending ladder of values, and compares every result beat with
// the next expected one.
// ----------------------------------------------------------------------------
module spq_order_checker
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  spq_in_t  in_data,
  input  logic     out_valid,
  input  spq_out_t out_data,
  output int       mismatches,
  output int       backlog,
  output int       results_seen,
  output int       refusals
);

  logic signed [VALUE_W-1:0] ladder [SPQ_CAPACITY];
  int                        depth_now;
  spq_out_t                  due_results [$];

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    if (mismatches < 50) begin
      $display("mismatch at %0t ns: %s got %0h, expected %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // applies one command to the ladder and returns the result it should give
  function automatic spq_out_t queue_step(input spq_in_t beat);
    spq_out_t                  res;
    logic signed [VALUE_W-1:0] v;
    int                        pos;
    res = '0;
    v   = beat.value_in;
    case (beat.cmd)
      CMD_INSERT: begin
        if (depth_now < SPQ_CAPACITY) begin
          pos = 0;
          // new value goes after every strictly greater one
          while (pos < depth_now && ladder[pos] > v) pos++;
          for (int k = depth_now; k > pos; k--) ladder[k] = ladder[k-1];
          ladder[pos] = v;
          depth_now++;
          res.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (depth_now > 0) begin
          res.value_out = ladder[0];
          for (int k = 1; k < depth_now; k++) ladder[k-1] = ladder[k];
          depth_now--;
          res.ok = 1'b1;
        end
      end
      CMD_CLEAR: begin
        depth_now = 0;
        res.ok    = 1'b1;
      end
      default: ;
    endcase
    res.empty_res = (depth_now == 0);
    res.count     = COUNT_W'(depth_now);
    return res;
  endfunction

  always @(posedge clk) begin
    spq_out_t want;
    if (!rst_n) begin
      depth_now = 0;
      due_results.delete();
    end else begin
      // a result never belongs to the beat taken at the same edge
      if (out_valid) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing outstanding, value_out", out_data.value_out,
                          '0);
        end else begin
          want = due_results.pop_front();
          if (out_data.ok !== want.ok)
            report_mismatch("ok", VALUE_W'(out_data.ok), VALUE_W'(want.ok));
          if (out_data.value_out !== want.value_out)
            report_mismatch("value_out", out_data.value_out, want.value_out);
          if (out_data.empty_res !== want.empty_res)
            report_mismatch("empty_res", VALUE_W'(out_data.empty_res), VALUE_W'(want.empty_res));
          if (out_data.count !== want.count)
            report_mismatch("count", VALUE_W'(out_data.count), VALUE_W'(want.count));
        end
      end
      if (start && !busy) begin
        want = queue_step(in_data);
        if (!want.ok) refusals++;
        due_results.push_back(want);
      end
    end
    backlog = due_results.size();
  end

endmodule

@@ sim/sorted_priority_queue_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Drives insert, remove, clear and unused commands into the sorted priority
// queue: a directed opening through the extremes, then random fill and drain
// stretches under several idling mixes. Results are judged by spq_order_checker.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int               LIMIT_CYCLES    = 300_000;
  localparam int               ITEMS_PER_PHASE = 140;
  localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spq_in_t  in_data = '0;
  logic     out_valid;
  spq_out_t out_data;

  int mismatches;
  int backlog;
  int results_seen;
  int refusals;
  int items_sent = 0;
  int cycles = 0;
  int idle_pct = 0;

  sorted_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  spq_order_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .backlog      (backlog),
    .results_seen (results_seen),
    .refusals     (refusals)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still outstanding", cycles, backlog);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // optional idle gap with junk on the bus, then one beat held until taken
  task automatic issue(input logic [CMD_W-1:0] op, input logic signed [VALUE_W-1:0] val);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= {CMD_W'($urandom), $urandom};
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_data <= '{cmd: op, value_in: val};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return VALUE_W'(int'($urandom_range(8)) - 4);  // many ties
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [VALUE_W-1:0] fill_vals [17];
    int                        phase_idle [4];
    logic [CMD_W-1:0]          op;
    int                        roll;
    int                        stretch_left;
    bit                        filling;
    fill_vals = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1, 32'sd5, 32'sd5,
                  32'sd5, -32'sd7, 32'sh7fffffff, 32'sh80000000, 32'sh55555555,
                  32'shaaaaaaaa, 32'sd100, -32'sd100, 32'sd5, 32'sd42};
    phase_idle   = '{0, 47, 0, 15};
    stretch_left = 0;
    filling      = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: refused remove, clear of nothing
    issue(CMD_REMOVE, 32'sh12345678);
    issue(CMD_CLEAR, -32'sd1);
    // fill past capacity, the last insert is refused
    for (int i = 0; i < 17; i++) issue(CMD_INSERT, fill_vals[i]);
    issue(CMD_UNUSED, -32'sd1);
    issue(CMD_REMOVE, 32'sh0);
    issue(CMD_CLEAR, 32'sh0);
    issue(CMD_REMOVE, 32'sh7fffffff);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // alternate fill-heavy and drain-heavy stretches to hit full and empty
        if (stretch_left == 0) begin
          filling      = !filling;
          stretch_left = $urandom_range(20, 50);
        end
        stretch_left--;
        roll = $urandom_range(99);
        if (roll < (filling ? 75 : 25)) op = CMD_INSERT;
        else if (roll < 98) op = CMD_REMOVE;
        else if (roll < 99) op = CMD_CLEAR;
        else op = CMD_UNUSED;
        issue(op, (op == CMD_INSERT) ? pick_value() : $urandom);
      end
    end

    start <= 1'b0;
    while (backlog != 0) @(posedge clk);
    repeat (SPQ_CAPACITY + 4) @(posedge clk);

    $display("sent %0d commands (fill and drain stretches, idling 0/47/15 per cent)",
             items_sent);
    $display("checked %0d results, %0d of them refused commands", results_seen, refusals);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_ram.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
sim/spq_order_checker.sv
sim/sorted_priority_queue_test.sv
